FILE: hw/rtl/rpip_pkg.sv
// Shared types, constants and helper functions for the radix-prefixed integer parser.
// The word types are used by rpip_scan and the top level; the digit decoder by rpip_scan.
package rpip_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] parsed_value;
    logic        parse_error;
    logic [5:0]  consumed_length;
  } out_word_t;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UC_A    = 8'h41;
  localparam logic [7:0] CHAR_UC_B    = 8'h42;
  localparam logic [7:0] CHAR_UC_F    = 8'h46;
  localparam logic [7:0] CHAR_UC_X    = 8'h58;
  localparam logic [7:0] CHAR_LC_A    = 8'h61;
  localparam logic [7:0] CHAR_LC_B    = 8'h62;
  localparam logic [7:0] CHAR_LC_F    = 8'h66;
  localparam logic [7:0] CHAR_LC_X    = 8'h78;

  localparam logic [2:0] WIDTH_BYTES_RESET = 3'd4;
  localparam logic       REG_WIDTH_BYTES   = 1'b0;

  typedef enum logic [1:0] {
    RADIX_BIN,
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_t;

  // Returns {valid, value}.
  function automatic logic [4:0] digit_decode(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      return {1'b1, t[3:0]};
    end
    if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      t = c - CHAR_LC_A + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      t = c - CHAR_UC_A + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

  function automatic logic [4:0] radix_value(input radix_t r);
    unique case (r)
      RADIX_BIN: return 5'd2;
      RADIX_OCT: return 5'd8;
      RADIX_DEC: return 5'd10;
      RADIX_HEX: return 5'd16;
      default:   return 5'd10;
    endcase
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] wb);
    unique case (wb)
      3'd0:    return 32'h0000_0000;
      3'd1:    return 32'h0000_00FF;
      3'd2:    return 32'h0000_FFFF;
      3'd3:    return 32'h00FF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

FILE: hw/rtl/radix_prefixed_int_parser_top.sv
// Top level of the radix-prefixed integer parser: input register, scan, result register.
// Depends on rpip_pkg and rpip_scan; holds the width_bytes register behind an APB port.
// A last character's result is captured in the result register when its word leaves the input stage.
// Throughput: one character word per cycle while the input is not stalled.
// A waiting result stalls the input only once another last character sits in the input stage.
// Reset (rst, synchronous): scan returns to head state, width_bytes to 4, stages empty.
module radix_prefixed_int_parser_top import rpip_pkg::*; #(
  parameter int MAX_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  in_word_t    char_word,
  output logic        result_valid,
  input  logic        result_stall,
  output out_word_t   result_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       width_wr;
  logic [2:0] width_bytes;
  logic       s1_valid;
  in_word_t   s1_word;
  logic       s1_adv;
  out_word_t  scan_result;

  assign pready   = 1'b1;
  assign width_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WIDTH_BYTES);
  assign prdata   = (paddr[2] == REG_WIDTH_BYTES) ? {29'd0, width_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_bytes <= WIDTH_BYTES_RESET;
    end else if (width_wr) begin
      width_bytes <= pwdata[2:0];
    end
  end

  assign s1_adv     = s1_valid && (!s1_word.is_last || !result_valid || !result_stall);
  assign char_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      s1_word <= char_word;
    end
  end

  rpip_scan #(
    .MAX_CHARS(MAX_CHARS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_adv),
    .word       (s1_word),
    .width_bytes(width_bytes),
    .result     (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_word.is_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_word.is_last) begin
      result_word <= scan_result;
    end
  end

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.parse_error |->
      result_word.parsed_value == 32'd0 && result_word.consumed_length == 6'd0)
    else $error("error result carries nonzero value or length");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> s1_valid && s1_word.is_last && result_valid)
    else $error("input stalled without a blocked last word");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && s1_word.is_last))
    else $error("result raised without a last word");

endmodule

FILE: hw/rtl/rpip_scan.sv
// Scan state and combinational update for one character word.
// Depends on rpip_pkg; produces the result word for the last character.
module rpip_scan import rpip_pkg::*; #(
  parameter int MAX_CHARS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_word_t   word,
  input  logic [2:0] width_bytes,
  output out_word_t  result
);

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  localparam logic [5:0] MaxCount = 6'(MAX_CHARS);

  phase_t      phase, phase_next;
  radix_t      radix, radix_next;
  logic [31:0] accumulator, accumulator_next;
  logic [5:0]  char_count, char_count_next;
  logic        error_seen, error_seen_next;

  logic [4:0]  dig;
  logic [4:0]  rad_val;
  logic        take;
  radix_t      rad_use;
  logic [31:0] acc_scaled;

  assign dig     = digit_decode(word.char_code);
  assign rad_use = (phase == PH_HEAD) ? RADIX_DEC :
                   (phase == PH_ZERO) ? RADIX_OCT : radix;
  assign rad_val = radix_value(rad_use);

  always_comb begin
    unique case (rad_use)
      RADIX_BIN: acc_scaled = {accumulator[30:0], 1'b0};
      RADIX_OCT: acc_scaled = {accumulator[28:0], 3'b000};
      RADIX_DEC: acc_scaled = {accumulator[28:0], 3'b000} + {accumulator[30:0], 1'b0};
      RADIX_HEX: acc_scaled = {accumulator[27:0], 4'b0000};
      default:   acc_scaled = accumulator;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    radix_next       = radix;
    accumulator_next = accumulator;
    char_count_next  = char_count;
    error_seen_next  = error_seen;
    take             = 1'b0;

    if (phase != PH_DONE && !error_seen) begin
      if (word.char_code == CHAR_NUL) begin
        phase_next = PH_DONE;
      end else if (char_count >= MaxCount) begin
        phase_next = PH_DONE;
      end else begin
        char_count_next = char_count + 6'd1;
        unique case (phase)
          PH_HEAD: begin
            if (word.char_code == CHAR_SPACE) begin
              phase_next = PH_HEAD;
            end else if (word.char_code == CHAR_ZERO) begin
              phase_next = PH_ZERO;
            end else begin
              phase_next = PH_DIGITS;
              radix_next = RADIX_DEC;
              take       = 1'b1;
            end
          end
          PH_ZERO: begin
            phase_next = PH_DIGITS;
            if (word.char_code == CHAR_LC_B || word.char_code == CHAR_UC_B) begin
              radix_next = RADIX_BIN;
            end else if (word.char_code == CHAR_LC_X || word.char_code == CHAR_UC_X) begin
              radix_next = RADIX_HEX;
            end else begin
              radix_next = RADIX_OCT;
              take       = 1'b1;
            end
          end
          default: begin
            take = 1'b1;
          end
        endcase
        if (take) begin
          if (!dig[4] || {1'b0, dig[3:0]} >= rad_val) begin
            error_seen_next = 1'b1;
            phase_next      = PH_DONE;
          end else begin
            accumulator_next = acc_scaled + {28'd0, dig[3:0]};
          end
        end
        if (phase_next != PH_DONE && char_count_next >= MaxCount) begin
          phase_next = PH_DONE;
        end
      end
    end
  end

  always_comb begin
    if (error_seen_next) begin
      result.parsed_value    = 32'd0;
      result.parse_error     = 1'b1;
      result.consumed_length = 6'd0;
    end else begin
      result.parsed_value    = accumulator_next & byte_mask(width_bytes);
      result.parse_error     = 1'b0;
      result.consumed_length = char_count_next + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      radix       <= RADIX_DEC;
      accumulator <= 32'd0;
      char_count  <= 6'd0;
      error_seen  <= 1'b0;
    end else if (step) begin
      if (word.is_last) begin
        phase       <= PH_HEAD;
        radix       <= RADIX_DEC;
        accumulator <= 32'd0;
        char_count  <= 6'd0;
        error_seen  <= 1'b0;
      end else begin
        phase       <= phase_next;
        radix       <= radix_next;
        accumulator <= accumulator_next;
        char_count  <= char_count_next;
        error_seen  <= error_seen_next;
      end
    end
  end

endmodule
